[src/twkb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the TWKB geometry decoder.
// Used by twkb_parse, twkb_evq and twkb_geometry_decoder; no dependencies.
package twkb_pkg;

    localparam int NRES = 8;                 // result beats one byte may cause
    localparam int RCW  = $clog2(NRES + 1);
    localparam int RIW  = $clog2(NRES);

    // parser phases
    localparam logic [4:0] PH_HDR1  = 5'd0;
    localparam logic [4:0] PH_HDR2  = 5'd1;
    localparam logic [4:0] PH_EXT   = 5'd2;
    localparam logic [4:0] PH_SIZE  = 5'd3;
    localparam logic [4:0] PH_BBOX  = 5'd4;
    localparam logic [4:0] PH_COUNT = 5'd5;
    localparam logic [4:0] PH_IDS   = 5'd6;
    localparam logic [4:0] PH_SUB   = 5'd7;
    localparam logic [4:0] PH_X     = 5'd8;
    localparam logic [4:0] PH_Y     = 5'd9;
    localparam logic [4:0] PH_Z     = 5'd10;
    localparam logic [4:0] PH_M     = 5'd11;
    localparam logic [4:0] PH_DONE  = 5'd12;
    localparam logic [4:0] PH_ERR   = 5'd13;

    // geometry types from the header
    localparam logic [3:0] GT_POINT = 4'd1;
    localparam logic [3:0] GT_LINE  = 4'd2;
    localparam logic [3:0] GT_POLY  = 4'd3;
    localparam logic [3:0] GT_MPT   = 4'd4;
    localparam logic [3:0] GT_MLINE = 4'd5;
    localparam logic [3:0] GT_MPOLY = 4'd6;
    localparam logic [3:0] GT_COLL  = 4'd7;

    // stack frame kinds
    localparam logic [2:0] K_RING  = 3'd0;
    localparam logic [2:0] K_LINE  = 3'd1;
    localparam logic [2:0] K_MPT   = 3'd2;
    localparam logic [2:0] K_POLY  = 3'd3;
    localparam logic [2:0] K_MPOLY = 3'd4;
    localparam logic [2:0] K_MLINE = 3'd5;
    localparam logic [2:0] K_COLL  = 3'd6;

    // result event kinds
    localparam logic [2:0] EV_START  = 3'd0;
    localparam logic [2:0] EV_VERTEX = 3'd1;
    localparam logic [2:0] EV_RING   = 3'd2;
    localparam logic [2:0] EV_POLY   = 3'd3;
    localparam logic [2:0] EV_DONE   = 3'd4;
    localparam logic [2:0] EV_TRUNC  = 3'd5;

    // path kinds
    localparam logic [1:0] PK_POINT = 2'd0;
    localparam logic [1:0] PK_LINE  = 2'd1;
    localparam logic [1:0] PK_POLY  = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] pkind;
        logic       keep;
        logic       prod;
    } event_t;

    typedef struct packed {
        logic [RCW-1:0]          n;
        event_t [NRES-1:0]       evs;
        logic [63:0]             x;
        logic [63:0]             y;
        logic [3:0]              prec;
    } batch_t;

    // phase that reads the next child of a frame
    function automatic logic [4:0] child_phase(input logic [2:0] k);
        logic [4:0] ph;
        if (k == K_RING || k == K_LINE || k == K_MPT) ph = PH_X;
        else if (k == K_COLL)                           ph = PH_HDR1;
        else                                            ph = PH_SUB;
        return ph;
    endfunction

endpackage

[src/twkb_parse.sv]
`timescale 1ns / 1ps
// Parser state and single-byte step logic: header, varints, frame stack.
// Depends on twkb_pkg; produces one batch of events per stepped byte.
module twkb_parse import twkb_pkg::*; #(
    parameter int MAX_NEST = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       in_first,
    input  logic       in_last,
    output batch_t     batch
);

    localparam int LW = $clog2(MAX_NEST + 1);
    localparam int IW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    logic [4:0]  phase_reg, c_phase, n_phase;
    logic [63:0] vv_reg, c_vv, n_vv;
    logic [6:0]  vs_reg, c_vs, n_vs;
    logic [7:0]  flags_reg, c_flags, n_flags;
    logic [3:0]  prec_reg, c_prec, n_prec;
    logic [63:0] xacc_reg, c_x, n_x;
    logic [63:0] yacc_reg, c_y, n_y;
    logic [31:0] cnt_reg [MAX_NEST];
    logic [2:0]  typ_reg [MAX_NEST];
    logic [LW-1:0] nest_reg, c_nest, n_nest;
    logic [31:0] skip_reg, c_skip, n_skip;
    logic [31:0] pv_reg, c_pv, n_pv;
    logic        kept_reg, c_kept, n_kept;
    logic [3:0]  gtype_reg, c_gtype, n_gtype;
    logic        firstv_reg, c_firstv, n_firstv;

    logic          fin_run;
    logic [LW-1:0] fin_lvl;
    logic [IW-1:0] fin_si;
    logic          fin_keep;
    logic [IW-1:0] tt_idx;
    logic [2:0]    top_type;

    logic          bb, as_en, st_en, do_fin, vd, dec_en;
    logic          push_en, push_ok, push_fv, push_pv0;
    logic [2:0]    push_k;
    logic [31:0]   push_c;
    logic [4:0]    push_ph;
    logic [63:0]   vacc, v, d;
    logic [31:0]   c32;
    logic [33:0]   pv_sum;
    logic [1:0]    pk;
    logic [RCW-1:0] ev_n;
    event_t [NRES-1:0] evs;

    always_comb begin
        // first byte clears the parser before use
        if (in_first) begin
            c_phase = PH_HDR1; c_vv = '0; c_vs = '0; c_flags = '0; c_prec = '0;
            c_x = '0; c_y = '0; c_nest = '0; c_skip = '0; c_pv = '0; c_kept = 1'b0;
            c_gtype = '0; c_firstv = 1'b0;
        end else begin
            c_phase = phase_reg; c_vv = vv_reg; c_vs = vs_reg; c_flags = flags_reg;
            c_prec = prec_reg; c_x = xacc_reg; c_y = yacc_reg; c_nest = nest_reg;
            c_skip = skip_reg; c_pv = pv_reg; c_kept = kept_reg; c_gtype = gtype_reg;
            c_firstv = firstv_reg;
        end

        tt_idx   = (c_nest == '0) ? IW'(MAX_NEST - 1) : IW'(c_nest - 1'b1);
        top_type = typ_reg[tt_idx];

        // frames that a finish pops: the run of top frames with a count of one
        fin_run = 1'b1;
        fin_lvl = c_nest;
        for (int i = MAX_NEST - 1; i >= 0; i--) begin
            if (i < int'(c_nest)) begin
                if (fin_run && cnt_reg[i] == 32'd1) fin_lvl = LW'(i);
                else fin_run = 1'b0;
            end
        end
        fin_si   = IW'(fin_lvl - 1'b1);
        fin_keep = (c_pv > 32'd3);

        n_phase = c_phase; n_vv = c_vv; n_vs = c_vs; n_flags = c_flags; n_prec = c_prec;
        n_x = c_x; n_y = c_y; n_nest = c_nest; n_skip = c_skip; n_pv = c_pv;
        n_kept = c_kept; n_gtype = c_gtype; n_firstv = c_firstv;

        bb = 1'b0; as_en = 1'b0; st_en = 1'b0; do_fin = 1'b0; vd = 1'b0; dec_en = 1'b0;
        push_en = 1'b0; push_ok = 1'b0; push_fv = 1'b0; push_pv0 = 1'b0;
        push_k = K_RING; push_c = '0; push_ph = PH_X;
        vacc = '0; v = '0; d = '0; c32 = '0; pv_sum = '0; pk = PK_POINT;
        ev_n = '0; evs = '0;

        case (c_phase)
            PH_HDR1: begin
                n_gtype = in_byte[3:0];
                n_prec  = in_byte[4] ? ~{1'b0, in_byte[7:5]} : {1'b0, in_byte[7:5]};
                n_phase = PH_HDR2;
            end
            PH_HDR2: begin
                n_flags = {3'b000, in_byte[4:0]};
                if (in_byte[3]) n_phase = PH_EXT;
                else bb = 1'b1;
            end
            PH_EXT: begin
                n_flags = c_flags | {1'b0, in_byte[1], in_byte[0], 5'b00000};
                bb = 1'b1;
            end
            PH_DONE, PH_ERR: begin
            end
            default: begin
                vacc = c_vv | (c_vs[6] ? 64'd0 : ({57'd0, in_byte[6:0]} << c_vs[5:0]));
                n_vs = (c_vs < 7'd70) ? c_vs + 7'd7 : c_vs;
                if (in_byte[7]) begin
                    n_vv = vacc;
                end else begin
                    n_vv = '0;
                    n_vs = '0;
                    v    = vacc;
                    d    = (v >> 1) ^ {64{v[0]}};
                    c32  = v[31:0];
                    case (c_phase)
                        PH_SIZE: as_en = 1'b1;
                        PH_BBOX: begin
                            n_skip = c_skip - 32'd1;
                            if (n_skip == '0) st_en = 1'b1;
                        end
                        PH_COUNT: begin
                            if (c32 == '0) begin
                                do_fin = 1'b1;
                            end else if (c_gtype == GT_LINE) begin
                                push_en = 1'b1; push_k = K_LINE; push_c = c32;
                                push_fv = 1'b1; push_ph = PH_X;
                            end else if (c_gtype == GT_POLY) begin
                                push_en = 1'b1; push_k = K_POLY; push_c = c32;
                                push_pv0 = 1'b1; push_ph = PH_SUB;
                            end else begin
                                push_en = 1'b1; push_c = c32;
                                if (c_gtype == GT_MPT)        push_k = K_MPT;
                                else if (c_gtype == GT_MLINE) push_k = K_MLINE;
                                else if (c_gtype == GT_MPOLY) push_k = K_MPOLY;
                                else                          push_k = K_COLL;
                                if (c_flags[2]) begin
                                    n_skip  = c32;
                                    push_ph = PH_IDS;
                                end else begin
                                    push_ph = child_phase(push_k);
                                end
                            end
                        end
                        PH_IDS: begin
                            n_skip = c_skip - 32'd1;
                            if (n_skip == '0) n_phase = child_phase(top_type);
                        end
                        PH_SUB: begin
                            if (c32 == '0) begin
                                do_fin = 1'b1;
                            end else if (top_type == K_MLINE) begin
                                push_en = 1'b1; push_k = K_LINE; push_c = c32;
                                push_fv = 1'b1; push_ph = PH_X;
                            end else if (top_type == K_MPOLY) begin
                                push_en = 1'b1; push_k = K_POLY; push_c = c32;
                                push_pv0 = 1'b1; push_ph = PH_SUB;
                            end else if (top_type == K_POLY) begin
                                pv_sum = {2'b00, c_pv} + {2'b00, c32} + 34'd1;
                                n_pv = (pv_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : pv_sum[31:0];
                                push_en = 1'b1; push_k = K_RING; push_c = c32;
                                push_fv = 1'b1; push_ph = PH_X;
                            end else begin
                                n_phase = PH_ERR;
                            end
                        end
                        PH_X: begin
                            n_x = c_x + d;
                            n_phase = PH_Y;
                        end
                        PH_Y: begin
                            n_y = c_y + d;
                            if (c_flags[5])      n_phase = PH_Z;
                            else if (c_flags[6]) n_phase = PH_M;
                            else                 vd = 1'b1;
                        end
                        PH_Z: begin
                            if (c_flags[6]) n_phase = PH_M;
                            else vd = 1'b1;
                        end
                        default: vd = 1'b1;
                    endcase
                end
            end
        endcase

        // header complete: start the body
        if (bb) begin
            n_x = '0;
            n_y = '0;
            if (n_flags[4])      do_fin = 1'b1;
            else if (n_flags[1]) n_phase = PH_SIZE;
            else                 as_en = 1'b1;
        end
        if (as_en) begin
            if (n_flags[0]) begin
                n_skip  = 32'd4 + {30'd0, n_flags[5], 1'b0} + {30'd0, n_flags[6], 1'b0};
                n_phase = PH_BBOX;
            end else begin
                st_en = 1'b1;
            end
        end
        if (st_en) begin
            if (n_gtype == GT_POINT) begin
                push_en = 1'b1; push_k = K_MPT; push_c = 32'd1; push_ph = PH_X;
            end else if (n_gtype >= GT_LINE && n_gtype <= GT_COLL) begin
                n_phase = PH_COUNT;
            end else begin
                do_fin = 1'b1;
            end
        end

        if (push_en) begin
            if (int'(c_nest) < MAX_NEST) begin
                push_ok = 1'b1;
                n_nest  = c_nest + 1'b1;
                n_phase = push_ph;
                if (push_fv)  n_firstv = 1'b1;
                if (push_pv0) n_pv = '0;
            end else begin
                n_phase = PH_ERR;
            end
        end

        if (vd) begin
            if (top_type == K_MPT) begin
                n_kept = 1'b1;
                if (ev_n < RCW'(NRES)) begin
                    evs[ev_n[RIW-1:0]] = '{kind: EV_START, pkind: PK_POINT, keep: 1'b0,
                                           prod: 1'b0};
                    ev_n = ev_n + 1'b1;
                end
            end else begin
                pk = (top_type == K_LINE) ? PK_LINE : PK_POLY;
                if (c_firstv && top_type == K_LINE) n_kept = 1'b1;
                if (ev_n < RCW'(NRES)) begin
                    evs[ev_n[RIW-1:0]] = '{kind: (c_firstv ? EV_START : EV_VERTEX),
                                           pkind: pk, keep: 1'b0, prod: 1'b0};
                    ev_n = ev_n + 1'b1;
                end
            end
            n_firstv = 1'b0;
            do_fin   = 1'b1;
        end

        // pop finished frames top down, emitting ring close and polygon end
        if (do_fin) begin
            for (int i = MAX_NEST - 1; i >= 0; i--) begin
                if (i < int'(c_nest) && i >= int'(fin_lvl)) begin
                    if (typ_reg[i] == K_RING) begin
                        if (ev_n < RCW'(NRES)) begin
                            evs[ev_n[RIW-1:0]] = '{kind: EV_RING, pkind: PK_POLY, keep: 1'b0,
                                                   prod: 1'b0};
                            ev_n = ev_n + 1'b1;
                        end
                    end else if (typ_reg[i] == K_POLY) begin
                        if (fin_keep) n_kept = 1'b1;
                        if (ev_n < RCW'(NRES)) begin
                            evs[ev_n[RIW-1:0]] = '{kind: EV_POLY, pkind: PK_POLY,
                                                   keep: fin_keep, prod: 1'b0};
                            ev_n = ev_n + 1'b1;
                        end
                    end
                end
            end
            n_nest = fin_lvl;
            if (fin_lvl == '0) begin
                n_phase = PH_DONE;
            end else begin
                dec_en  = 1'b1;
                n_phase = child_phase(typ_reg[fin_si]);
            end
        end

        batch.prec = n_prec;
        batch.x    = n_x;
        batch.y    = n_y;

        if (in_last) begin
            if (ev_n < RCW'(NRES)) begin
                evs[ev_n[RIW-1:0]] = (n_phase == PH_DONE)
                    ? event_t'{kind: EV_DONE, pkind: PK_POINT, keep: 1'b0, prod: n_kept}
                    : event_t'{kind: EV_TRUNC, pkind: PK_POINT, keep: 1'b0, prod: 1'b0};
                ev_n = ev_n + 1'b1;
            end
            n_phase = PH_HDR1; n_vv = '0; n_vs = '0; n_flags = '0; n_prec = '0;
            n_x = '0; n_y = '0; n_nest = '0; n_skip = '0; n_pv = '0; n_kept = 1'b0;
            n_gtype = '0; n_firstv = 1'b0;
        end

        batch.n   = ev_n;
        batch.evs = evs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR1; vv_reg <= '0; vs_reg <= '0; flags_reg <= '0;
            prec_reg <= '0; xacc_reg <= '0; yacc_reg <= '0; nest_reg <= '0;
            skip_reg <= '0; pv_reg <= '0; kept_reg <= 1'b0; gtype_reg <= '0;
            firstv_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= n_phase; vv_reg <= n_vv; vs_reg <= n_vs; flags_reg <= n_flags;
            prec_reg <= n_prec; xacc_reg <= n_x; yacc_reg <= n_y; nest_reg <= n_nest;
            skip_reg <= n_skip; pv_reg <= n_pv; kept_reg <= n_kept; gtype_reg <= n_gtype;
            firstv_reg <= n_firstv;
        end
    end

    // frame stack: one push or one count decrement per byte
    always_ff @(posedge aclk) begin
        if (step && push_ok) begin
            typ_reg[c_nest[IW-1:0]] <= push_k;
            cnt_reg[c_nest[IW-1:0]] <= push_c;
        end
        if (step && dec_en) begin
            cnt_reg[fin_si] <= cnt_reg[fin_si] - 32'd1;
        end
    end

endmodule

[src/twkb_evq.sv]
`timescale 1ns / 1ps
// Result buffer: holds the events of one byte and sends them one beat each.
// Depends on twkb_pkg.
module twkb_evq import twkb_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  batch_t       batch,
    output logic         can_load,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // x_coord, y_coord, precision, keep_polygon,
                                    // produced_any, zero fill
    output logic [4:0]   m_tuser,   // event_kind, path_kind
    output logic         m_tlast    // last_of_run
);

    event_t [NRES-1:0] evs_reg;
    logic [RCW-1:0]    rem_reg;
    logic [RIW-1:0]    idx_reg;
    logic [63:0]       x_reg, y_reg;
    logic [3:0]        prec_reg;
    event_t            cur;
    logic              vert, take;

    assign take     = m_tvalid && m_tready;
    assign can_load = (rem_reg == '0) || (rem_reg == RCW'(1) && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            rem_reg <= batch.n;
            idx_reg <= '0;
        end else if (take) begin
            rem_reg <= rem_reg - 1'b1;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            evs_reg  <= batch.evs;
            x_reg    <= batch.x;
            y_reg    <= batch.y;
            prec_reg <= batch.prec;
        end
    end

    assign cur      = evs_reg[idx_reg];
    assign vert     = (cur.kind == EV_START) || (cur.kind == EV_VERTEX);
    assign m_tvalid = (rem_reg != '0);
    assign m_tlast  = (rem_reg == RCW'(1));
    assign m_tuser  = {cur.pkind, cur.kind};
    assign m_tdata  = {2'b00, cur.prod, cur.keep, prec_reg,
                       (vert ? y_reg : 64'd0), (vert ? x_reg : 64'd0)};

endmodule

[src/twkb_geometry_decoder.sv]
`timescale 1ns / 1ps
// TWKB geometry decoder, top level: input beat register, parser, result buffer.
// Depends on twkb_pkg, twkb_parse and twkb_evq.

// One encoded byte enters per beat. A byte is registered when taken and parsed
// once the result buffer can load, and its results (vertices, ring closes,
// polygon ends, buffer done or truncated) leave one beat each from that buffer.
// With at most one result per byte and no output stall, the sustained rate is
// one byte per cycle; a byte with n results holds the input until its last beat
// is taken, n being at most four (a vertex, a ring close, a polygon end and the
// buffer end). The buffer takes the next byte's results in the cycle its last
// beat is taken. Coordinates are raw accumulated integers, to be scaled by ten
// to the minus precision. No clearing pass after reset.
module twkb_geometry_decoder import twkb_pkg::*; #(
    parameter int MAX_NEST = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // byte_value
    input  logic [0:0]   s_tuser,   // first_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // x_coord, y_coord, precision, keep_polygon,
                                    // produced_any, zero fill
    output logic [4:0]   m_tuser,   // event_kind, path_kind
    output logic         m_tlast    // last_of_run
);

    logic       in_v_reg;
    logic [7:0] byte_reg;
    logic       first_reg, last_reg;
    logic       step, can_load;
    batch_t     batch;

    assign step     = in_v_reg && can_load;
    assign s_tready = !in_v_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tready) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg  <= s_tdata;
            first_reg <= s_tuser[0];
            last_reg  <= s_tlast;
        end
    end

    twkb_parse #(.MAX_NEST(MAX_NEST)) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .in_byte  (byte_reg),
        .in_first (first_reg),
        .in_last  (last_reg),
        .batch    (batch)
    );

    twkb_evq u_evq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .batch    (batch),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // buffer end is always the final beat of its byte
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:0] == EV_DONE || m_tuser[2:0] == EV_TRUNC)) |-> m_tlast)
        else $error("buffer end beat without last");

    // coordinates only on vertex beats
    a_xy_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:0] != EV_START && m_tuser[2:0] != EV_VERTEX)
        |-> (m_tdata[127:0] == 128'd0))
        else $error("nonzero coordinates on a non-vertex beat");

    // a waiting input byte holds until parsed
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_v_reg && !step) |=> (in_v_reg && $stable(byte_reg)))
        else $error("input byte lost while stalled");
`endif

endmodule

[test/tb_twkb_geometry_decoder.sv]
`timescale 1ns / 1ps
// Self-checking bench for twkb_geometry_decoder: streams TWKB byte buffers and checks
// every vertex, ring, polygon and buffer-end beat against a built-in geometry walker.
// Depends on twkb_pkg and the RTL of twkb_geometry_decoder.
module tb_twkb_geometry_decoder;
    import twkb_pkg::*;

    localparam int DEPTH     = 4;
    localparam int MAX_CYC   = 400000;
    localparam int PHASE_LEN = 40;

    typedef struct {
        logic [7:0] data;
        logic       head;
        logic       tail;
    } byte_beat_t;

    typedef struct {
        logic [2:0]  kind;
        logic [1:0]  pk;
        logic [63:0] x;
        logic [63:0] y;
        logic [3:0]  prec;
        logic        keep;
        logic        prod;
        logic        tail;
    } geo_event_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic [4:0]   m_tuser;
    logic         m_tlast;

    twkb_geometry_decoder #(.MAX_NEST(DEPTH)) uut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    byte_beat_t  pending_bytes[$];
    geo_event_t  expected_events[$];
    geo_event_t  step_events[$];
    logic [7:0]  gbytes[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          errors = 0;
    int          cycles = 0;
    logic        byte_taken = 1'b0;
    byte_beat_t  cur_beat;

    // walker state
    logic [4:0]  w_phase;
    logic [63:0] w_vval;
    int          w_vshift;
    logic [7:0]  w_flags;
    logic [3:0]  w_prec;
    logic [63:0] w_x, w_y;
    logic [31:0] w_cnt[DEPTH];
    logic [2:0]  w_kind[DEPTH];
    int          w_lvl;
    logic [31:0] w_skip;
    logic [31:0] w_pverts;
    logic        w_kept;
    logic [3:0]  w_gtype;
    logic        w_firstv;

    function automatic void add_byte(logic [7:0] b);
        gbytes = {gbytes, b};
    endfunction

    function automatic void geo_emit(logic [2:0] k, logic [1:0] pk, logic [63:0] x,
                                     logic [63:0] y, logic keep, logic prod);
        geo_event_t e;
        if (step_events.size() >= NRES) return;
        e.kind = k; e.pk = pk; e.x = x; e.y = y; e.prec = w_prec;
        e.keep = keep; e.prod = prod; e.tail = 1'b0;
        step_events = {step_events, e};
    endfunction

    function automatic void geo_clear();
        w_phase = PH_HDR1; w_vval = '0; w_vshift = 0; w_flags = '0; w_prec = '0;
        w_x = '0; w_y = '0; w_lvl = 0; w_skip = '0; w_pverts = '0; w_kept = 1'b0;
        w_gtype = '0; w_firstv = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            w_cnt[i] = '0;
            w_kind[i] = K_RING;
        end
    endfunction

    function automatic logic geo_push(logic [2:0] k, logic [31:0] c);
        if (w_lvl >= DEPTH) begin
            w_phase = PH_ERR;
            return 1'b0;
        end
        w_kind[w_lvl] = k;
        w_cnt[w_lvl] = c;
        w_lvl++;
        return 1'b1;
    endfunction

    function automatic logic [2:0] top_kind();
        return w_kind[(w_lvl - 1) & (DEPTH - 1)];
    endfunction

    function automatic void geo_next();
        logic [2:0] k;
        k = top_kind();
        if (k == K_RING || k == K_LINE || k == K_MPT) w_phase = PH_X;
        else if (k == K_COLL) w_phase = PH_HDR1;
        else w_phase = PH_SUB;
    endfunction

    // close the current child, popping every frame it completes
    function automatic void geo_finish();
        int t;
        logic keep;
        while (w_lvl > 0) begin
            t = w_lvl - 1;
            w_cnt[t] = w_cnt[t] - 1;
            if (w_cnt[t] != 0) begin
                geo_next();
                return;
            end
            w_lvl = t;
            if (w_kind[t] == K_RING) begin
                geo_emit(EV_RING, PK_POLY, '0, '0, 1'b0, 1'b0);
            end else if (w_kind[t] == K_POLY) begin
                keep = w_pverts > 3;
                if (keep) w_kept = 1'b1;
                geo_emit(EV_POLY, PK_POLY, '0, '0, keep, 1'b0);
            end
        end
        w_phase = PH_DONE;
    endfunction

    function automatic void geo_start_type();
        if (w_gtype == GT_POINT) begin
            if (geo_push(K_MPT, 32'd1)) w_phase = PH_X;
        end else if (w_gtype >= GT_LINE && w_gtype <= GT_COLL) begin
            w_phase = PH_COUNT;
        end else begin
            geo_finish();
        end
    endfunction

    function automatic void geo_after_size();
        if (w_flags[0]) begin
            w_skip = 4 + (w_flags[5] ? 2 : 0) + (w_flags[6] ? 2 : 0);
            w_phase = PH_BBOX;
        end else begin
            geo_start_type();
        end
    endfunction

    function automatic void geo_body();
        w_x = '0;
        w_y = '0;
        if (w_flags[4]) geo_finish();
        else if (w_flags[1]) w_phase = PH_SIZE;
        else geo_after_size();
    endfunction

    function automatic void geo_open_points(logic [2:0] k, logic [31:0] c);
        if (geo_push(k, c)) begin
            w_firstv = 1'b1;
            w_phase = PH_X;
        end
    endfunction

    function automatic void geo_open_poly(logic [31:0] c);
        if (geo_push(K_POLY, c)) begin
            w_pverts = '0;
            w_phase = PH_SUB;
        end
    endfunction

    function automatic void geo_count(logic [31:0] c);
        logic [2:0] k;
        if (c == 0) begin
            geo_finish();
            return;
        end
        if (w_gtype == GT_LINE) begin
            geo_open_points(K_LINE, c);
            return;
        end
        if (w_gtype == GT_POLY) begin
            geo_open_poly(c);
            return;
        end
        k = w_gtype == GT_MPT ? K_MPT : w_gtype == GT_MLINE ? K_MLINE :
            w_gtype == GT_MPOLY ? K_MPOLY : K_COLL;
        if (geo_push(k, c)) begin
            if (w_flags[2]) begin
                w_skip = c;
                w_phase = PH_IDS;
            end else begin
                geo_next();
            end
        end
    endfunction

    function automatic void geo_sub(logic [31:0] c);
        logic [2:0]  k;
        logic [63:0] s;
        k = top_kind();
        if (c == 0) begin
            geo_finish();
            return;
        end
        if (k == K_MLINE) begin
            geo_open_points(K_LINE, c);
        end else if (k == K_MPOLY) begin
            geo_open_poly(c);
        end else if (k == K_POLY) begin
            s = {32'b0, w_pverts} + {32'b0, c} + 64'd1;
            geo_open_points(K_RING, c);
            w_pverts = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
        end else begin
            w_phase = PH_ERR;
        end
    endfunction

    function automatic void geo_vertex();
        logic [2:0] k;
        logic [1:0] pk;
        k = top_kind();
        if (k == K_MPT) begin
            w_kept = 1'b1;
            geo_emit(EV_START, PK_POINT, w_x, w_y, 1'b0, 1'b0);
        end else begin
            pk = k == K_LINE ? PK_LINE : PK_POLY;
            if (w_firstv) begin
                if (k == K_LINE) w_kept = 1'b1;
                geo_emit(EV_START, pk, w_x, w_y, 1'b0, 1'b0);
            end else begin
                geo_emit(EV_VERTEX, pk, w_x, w_y, 1'b0, 1'b0);
            end
        end
        w_firstv = 1'b0;
        geo_finish();
    endfunction

    function automatic void geo_value(logic [63:0] v);
        logic [63:0] d;
        d = (v >> 1) ^ {64{v[0]}};
        case (w_phase)
            PH_SIZE: geo_after_size();
            PH_BBOX: begin
                w_skip = w_skip - 1;
                if (w_skip == 0) geo_start_type();
            end
            PH_COUNT: geo_count(v[31:0]);
            PH_IDS: begin
                w_skip = w_skip - 1;
                if (w_skip == 0) geo_next();
            end
            PH_SUB: geo_sub(v[31:0]);
            PH_X: begin
                w_x = w_x + d;
                w_phase = PH_Y;
            end
            PH_Y: begin
                w_y = w_y + d;
                if (w_flags[5]) w_phase = PH_Z;
                else if (w_flags[6]) w_phase = PH_M;
                else geo_vertex();
            end
            PH_Z: begin
                if (w_flags[6]) w_phase = PH_M;
                else geo_vertex();
            end
            default: geo_vertex();
        endcase
    endfunction

    function automatic void geo_byte(logic [7:0] b);
        logic [3:0]  n;
        logic [63:0] v;
        case (w_phase)
            PH_HDR1: begin
                w_gtype = b[3:0];
                n = b[7:4];
                w_prec = n[0] ? 4'(16 - ((int'(n) + 1) >> 1)) : (n >> 1);
                w_phase = PH_HDR2;
                return;
            end
            PH_HDR2: begin
                w_flags = {3'b0, b[4:0]};
                if (b[3]) w_phase = PH_EXT;
                else geo_body();
                return;
            end
            PH_EXT: begin
                w_flags[5] = b[0];
                w_flags[6] = b[1];
                geo_body();
                return;
            end
            PH_DONE, PH_ERR: return;
            default: ;
        endcase
        if (w_vshift < 64) w_vval = w_vval | (64'(b[6:0]) << w_vshift);
        if (w_vshift < 70) w_vshift += 7;
        if (b[7]) return;
        v = w_vval;
        w_vval = '0;
        w_vshift = 0;
        geo_value(v);
    endfunction

    // advance the walker by one byte and queue the beats it causes
    function automatic void predict_events(byte_beat_t it);
        step_events.delete();
        if (it.head) geo_clear();
        geo_byte(it.data);
        if (it.tail) begin
            if (w_phase == PH_DONE) geo_emit(EV_DONE, PK_POINT, '0, '0, 1'b0, w_kept);
            else geo_emit(EV_TRUNC, PK_POINT, '0, '0, 1'b0, 1'b0);
            geo_clear();
        end
        if (step_events.size() > 0) step_events[step_events.size() - 1].tail = 1'b1;
        foreach (step_events[i]) expected_events = {expected_events, step_events[i]};
    endfunction

    // ---------------- stimulus generation ----------------
    function automatic void put_varint(logic [63:0] v, int pad);
        logic [7:0] b;
        logic       more;
        do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            more = (v != 0) || (pad > 0);
            if (v == 0 && pad > 0) pad--;
            if (more) b[7] = 1'b1;
            add_byte(b);
        end while (more);
    endfunction

    function automatic logic [63:0] rand_value();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 64'($urandom_range(0, 300));
        if (r < 90) return 64'($urandom);
        return {$urandom, $urandom};
    endfunction

    function automatic void put_any();
        put_varint(rand_value(), $urandom_range(99) < 5 ? $urandom_range(1, 4) : 0);
    endfunction

    function automatic void put_point(logic hz, logic hm);
        put_any();
        put_any();
        if (hz) put_any();
        if (hm) put_any();
    endfunction

    function automatic int rand_count(int hi);
        return $urandom_range(99) < 8 ? 0 : $urandom_range(1, hi);
    endfunction

    function automatic void put_points(int c, logic hz, logic hm);
        for (int i = 0; i < c; i++) put_point(hz, hm);
    endfunction

    function automatic void put_polygon(logic hz, logic hm);
        int r, p;
        r = rand_count(3);
        put_varint(64'(r), 0);
        for (int i = 0; i < r; i++) begin
            p = rand_count(4);
            put_varint(64'(p), 0);
            put_points(p, hz, hm);
        end
    endfunction

    function automatic void put_geometry(int lvl);
        logic [3:0] gt;
        logic [7:0] fl, ext;
        logic       hz, hm;
        int         c, r;
        r = $urandom_range(99);
        if (r < 12) gt = GT_POINT;
        else if (r < 30) gt = GT_LINE;
        else if (r < 50) gt = GT_POLY;
        else if (r < 60) gt = GT_MPT;
        else if (r < 70) gt = GT_MLINE;
        else if (r < 80) gt = GT_MPOLY;
        else if (r < 92 && lvl < 2) gt = GT_COLL;
        else if (r < 96) gt = GT_POLY;
        else gt = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(8, 15));
        fl = 8'($urandom_range(0, 7)) << 5;
        fl[0] = $urandom_range(99) < 25;
        fl[1] = $urandom_range(99) < 25;
        fl[2] = $urandom_range(99) < 30;
        fl[3] = $urandom_range(99) < 30;
        fl[4] = $urandom_range(99) < 5;
        add_byte({4'($urandom_range(0, 15)), gt});
        add_byte(fl);
        hz = 1'b0;
        hm = 1'b0;
        if (fl[3]) begin
            ext = 8'($urandom);
            add_byte(ext);
            hz = ext[0];
            hm = ext[1];
        end
        if (fl[4]) return;
        if (fl[1]) put_any();
        if (fl[0]) for (int i = 0; i < 4 + (hz ? 2 : 0) + (hm ? 2 : 0); i++) put_any();
        case (gt)
            GT_POINT: put_point(hz, hm);
            GT_LINE: begin
                c = rand_count(4);
                put_varint(64'(c), 0);
                put_points(c, hz, hm);
            end
            GT_POLY: put_polygon(hz, hm);
            GT_MPT, GT_MLINE, GT_MPOLY, GT_COLL: begin
                c = rand_count(3);
                put_varint(64'(c), 0);
                if (fl[2] && c > 0) for (int i = 0; i < c; i++) put_any();
                for (int i = 0; i < c; i++) begin
                    if (gt == GT_MPT) put_point(hz, hm);
                    else if (gt == GT_MLINE) begin
                        r = rand_count(4);
                        put_varint(64'(r), 0);
                        put_points(r, hz, hm);
                    end else if (gt == GT_MPOLY) put_polygon(hz, hm);
                    else put_geometry(lvl + 1);
                end
            end
            default: ;
        endcase
    endfunction

    // queue the collected bytes as one buffer
    function automatic void send_buffer(logic with_head);
        byte_beat_t it;
        foreach (gbytes[i]) begin
            it.data = gbytes[i];
            it.head = (i == 0) && with_head;
            it.tail = (i == gbytes.size() - 1);
            pending_bytes = {pending_bytes, it};
        end
        gbytes.delete();
    endfunction

    function automatic void add_random_buffer();
        int r, n;
        r = $urandom_range(99);
        if (r < 8) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) add_byte(8'($urandom));
            send_buffer($urandom_range(0, 1) == 1);
            return;
        end
        put_geometry(0);
        if (r < 25) for (int i = $urandom_range(1, 3); i > 0; i--) add_byte(8'($urandom));
        else if (r < 40) begin
            n = $urandom_range(1, gbytes.size());
            while (gbytes.size() > n) void'(gbytes.pop_back());
        end
        send_buffer(1'b1);
    endfunction

    function automatic void add_directed();
        // largest precision code, coordinate varint running past bit 63
        gbytes = '{8'hF1, 8'h00};
        for (int i = 0; i < 9; i++) add_byte(8'hFF);
        add_byte(8'hFF);
        add_byte(8'h7F);
        add_byte(8'h01);
        send_buffer(1'b1);
        // empty point
        gbytes = '{8'h21, 8'h10};
        send_buffer(1'b1);
        // unknown type
        gbytes = '{8'h08, 8'h00};
        send_buffer(1'b1);
        // collections nested past the stack depth
        gbytes = '{8'h07, 8'h00, 8'h01, 8'h07, 8'h00, 8'h01, 8'h07, 8'h00, 8'h01,
                   8'h07, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01, 8'h00};
        send_buffer(1'b1);
    endfunction

    // ---------------- driver / monitor ----------------
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || byte_taken) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_beat = pending_bytes.pop_front();
                    s_tdata  = cur_beat.data;
                    s_tuser  = cur_beat.head;
                    s_tlast  = cur_beat.tail;
                    s_tvalid = 1'b1;
                end else begin
                    s_tvalid = 1'b0;
                end
            end
            byte_taken = 1'b0;
            m_tready = $urandom_range(99) >= recv_stall_pct;
        end
    end

    always @(posedge aclk) begin
        geo_event_t e;
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("** twkb_geometry_decoder: FAILED **");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                $error("result beat with nothing expected: kind %0d", m_tuser[2:0]);
                errors++;
            end else begin
                e = expected_events.pop_front();
                if (m_tuser[2:0] !== e.kind) begin
                    $error("event_kind expected %0d got %0d", e.kind, m_tuser[2:0]);
                    errors++;
                end
                if (m_tuser[4:3] !== e.pk) begin
                    $error("path_kind expected %0d got %0d", e.pk, m_tuser[4:3]);
                    errors++;
                end
                if (m_tdata[63:0] !== e.x) begin
                    $error("x_coord expected %h got %h", e.x, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[127:64] !== e.y) begin
                    $error("y_coord expected %h got %h", e.y, m_tdata[127:64]);
                    errors++;
                end
                if (m_tdata[131:128] !== e.prec) begin
                    $error("precision expected %h got %h", e.prec, m_tdata[131:128]);
                    errors++;
                end
                if (m_tdata[132] !== e.keep) begin
                    $error("keep_polygon expected %b got %b", e.keep, m_tdata[132]);
                    errors++;
                end
                if (m_tdata[133] !== e.prod) begin
                    $error("produced_any expected %b got %b", e.prod, m_tdata[133]);
                    errors++;
                end
                if (m_tlast !== e.tail) begin
                    $error("last_of_run expected %b got %b", e.tail, m_tlast);
                    errors++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            predict_events(cur_beat);
            byte_taken = 1'b1;
        end
    end

    initial begin
        int idle_pct[4];
        int stall_pct[4];
        idle_pct  = '{0, 66, 0, 34};
        stall_pct = '{0, 0, 66, 34};
        geo_clear();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            if (ph == 0) add_directed();
            while (pending_bytes.size() < PHASE_LEN) add_random_buffer();
            // hold the next phase until everything has drained
            wait (pending_bytes.size() == 0 && !s_tvalid);
            wait (expected_events.size() == 0);
            repeat (4) @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_events.size() == 0) begin
            $display("** twkb_geometry_decoder: PASSED **");
        end else begin
            $display("** twkb_geometry_decoder: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
src/twkb_pkg.sv
src/twkb_parse.sv
src/twkb_evq.sv
src/twkb_geometry_decoder.sv
test/tb_twkb_geometry_decoder.sv
